// ===== rtl/sdinit_pkg.sv =====
// Types, codes and frame constants shared by the SD card SPI init sequencer.
`default_nettype none

package sdinit_pkg;

    // Request codes carried by one input transaction
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_XFER  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DUMMY_BYTES = 2'd0;
    localparam logic [1:0] CFG_POLL_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [3:0] DUMMY_BYTES_RST = 4'd10;
    localparam logic [3:0] POLL_LIMIT_RST  = 4'd10;
    localparam logic [9:0] RETRY_LIMIT_RST = 10'd1000;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IO_ERR  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // Bytes on the wire
    localparam logic [7:0] BYTE_IDLE    = 8'hFF;
    localparam logic [7:0] CMD_START    = 8'h40;
    localparam logic [7:0] CRC_CMD0     = 8'h95;
    localparam logic [7:0] CRC_CMD8     = 8'h87;
    localparam logic [7:0] CRC_NONE     = 8'hFF;
    localparam logic [7:0] R1_IDLE      = 8'h01;
    localparam logic [7:0] R1_READY     = 8'h00;
    localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
    localparam logic [31:0] ARG_ACMD41  = 32'h4000_0000;

    // Frame byte positions
    localparam logic [2:0] FRAME_LAST = 3'd6;
    localparam logic [2:0] R7_LAST    = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DUMMY,
        PH_FRAME,
        PH_POLL,
        PH_R7,
        PH_WAIT
    } t_phase;

    typedef enum logic [1:0] {
        CMD_GO_IDLE,
        CMD_IF_COND,
        CMD_APP,
        CMD_SEND_OP
    } t_cmd;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       wait_tick;
        logic       fast_clock;
        logic       done_res;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic [3:0] dummy_bytes;
        logic [3:0] poll_limit;
        logic [9:0] retry_limit;
    } t_cfg;

    function automatic logic [7:0] frame_byte(input t_cmd cmd, input logic [2:0] idx);
        logic [7:0]  code;
        logic [31:0] arg;
        logic [7:0]  crc;
        logic [7:0]  b;
        code = 8'd0;
        arg  = 32'd0;
        crc  = CRC_NONE;
        unique case (cmd)
            CMD_GO_IDLE: begin
                code = 8'd0;
                crc  = CRC_CMD0;
            end
            CMD_IF_COND: begin
                code = 8'd8;
                arg  = ARG_CMD8;
                crc  = CRC_CMD8;
            end
            CMD_APP: begin
                code = 8'd55;
            end
            default: begin
                code = 8'd41;
                arg  = ARG_ACMD41;
            end
        endcase
        case (idx)
            3'd0:    b = CMD_START | code;
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = crc;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdinit_core.sv =====
// Sequencer state and the combinational decision for each registered transaction.
`default_nettype none

module sdinit_core
    import sdinit_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    t_phase     r_phase,       n_phase;
    t_cmd       r_cmd,         n_cmd;
    logic [2:0] r_frame_index, n_frame_index;
    logic [3:0] r_dummy_left,  n_dummy_left;
    logic [3:0] r_poll_count,  n_poll_count;
    logic [9:0] r_retry_count, n_retry_count;
    logic       r_clock_sel,   n_clock_sel;

    logic [3:0] dummy_n;
    logic [3:0] poll_lim;
    logic [9:0] retry_lim;
    logic [9:0] retry_inc;
    logic       poll_done;
    logic       retry_out;

    // Zero in a limit register acts as one
    assign dummy_n   = (i_cfg.dummy_bytes == 4'd0) ? 4'd1 : i_cfg.dummy_bytes;
    assign poll_lim  = (i_cfg.poll_limit == 4'd0) ? 4'd1 : i_cfg.poll_limit;
    assign retry_lim = (i_cfg.retry_limit == 10'd0) ? 10'd1 : i_cfg.retry_limit;
    assign retry_inc = r_retry_count + 10'd1;
    assign poll_done = !i_rx_byte[7] || (r_poll_count >= poll_lim);
    assign retry_out = retry_inc >= retry_lim;

    // Next state
    always_comb begin
        n_phase       = r_phase;
        n_cmd         = r_cmd;
        n_frame_index = r_frame_index;
        n_dummy_left  = r_dummy_left;
        n_poll_count  = r_poll_count;
        n_retry_count = r_retry_count;
        n_clock_sel   = r_clock_sel;
        case (i_req_type)
            REQ_START: begin
                n_clock_sel   = 1'b0;
                n_retry_count = 10'd0;
                n_poll_count  = 4'd0;
                n_frame_index = 3'd0;
                n_phase       = PH_DUMMY;
                n_dummy_left  = dummy_n - 4'd1;
            end
            REQ_TICK: begin
                if (r_phase == PH_WAIT) begin
                    n_phase       = PH_FRAME;
                    n_cmd         = CMD_APP;
                    n_frame_index = 3'd1;
                end
            end
            REQ_XFER: begin
                unique case (r_phase)
                    PH_DUMMY: begin
                        if (r_dummy_left != 4'd0) begin
                            n_dummy_left = r_dummy_left - 4'd1;
                        end else begin
                            n_phase       = PH_FRAME;
                            n_cmd         = CMD_GO_IDLE;
                            n_frame_index = 3'd1;
                        end
                    end
                    PH_FRAME: begin
                        if (r_frame_index < FRAME_LAST) begin
                            n_frame_index = r_frame_index + 3'd1;
                        end else begin
                            n_phase      = PH_POLL;
                            n_poll_count = 4'd1;
                        end
                    end
                    PH_POLL: begin
                        if (poll_done) begin
                            unique case (r_cmd)
                                CMD_GO_IDLE: begin
                                    if (i_rx_byte != R1_IDLE) begin
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_phase       = PH_FRAME;
                                        n_cmd         = CMD_IF_COND;
                                        n_frame_index = 3'd1;
                                    end
                                end
                                CMD_IF_COND: begin
                                    if (i_rx_byte[2]) begin
                                        n_phase = PH_IDLE;
                                    end else if (i_rx_byte == R1_IDLE) begin
                                        n_phase       = PH_R7;
                                        n_frame_index = 3'd1;
                                    end else begin
                                        n_phase       = PH_FRAME;
                                        n_cmd         = CMD_APP;
                                        n_frame_index = 3'd1;
                                    end
                                end
                                CMD_APP: begin
                                    n_phase       = PH_FRAME;
                                    n_cmd         = CMD_SEND_OP;
                                    n_frame_index = 3'd1;
                                end
                                default: begin
                                    if (i_rx_byte == R1_READY) begin
                                        n_clock_sel = 1'b1;
                                        n_phase     = PH_IDLE;
                                    end else begin
                                        n_retry_count = retry_inc;
                                        n_phase       = retry_out ? PH_IDLE : PH_WAIT;
                                    end
                                end
                            endcase
                        end else begin
                            n_poll_count = r_poll_count + 4'd1;
                        end
                    end
                    PH_R7: begin
                        if (r_frame_index < R7_LAST) begin
                            n_frame_index = r_frame_index + 3'd1;
                        end else begin
                            n_phase       = PH_FRAME;
                            n_cmd         = CMD_APP;
                            n_frame_index = 3'd1;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Result of this transaction
    always_comb begin
        o_result            = '0;
        o_result.fast_clock = n_clock_sel;
        case (i_req_type)
            REQ_START: begin
                o_result.tx_valid = 1'b1;
                o_result.tx_byte  = BYTE_IDLE;
            end
            REQ_TICK: begin
                if (r_phase == PH_WAIT) begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_byte  = frame_byte(CMD_APP, 3'd0);
                end
            end
            REQ_XFER: begin
                unique case (r_phase)
                    PH_DUMMY: begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_byte  = (r_dummy_left != 4'd0)
                                          ? BYTE_IDLE : frame_byte(CMD_GO_IDLE, 3'd0);
                    end
                    PH_FRAME: begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_byte  = (r_frame_index < FRAME_LAST)
                                          ? frame_byte(r_cmd, r_frame_index) : BYTE_IDLE;
                    end
                    PH_POLL: begin
                        if (poll_done) begin
                            unique case (r_cmd)
                                CMD_GO_IDLE: begin
                                    if (i_rx_byte != R1_IDLE) begin
                                        o_result.done_res = 1'b1;
                                        o_result.status   = ST_IO_ERR;
                                    end else begin
                                        o_result.tx_valid = 1'b1;
                                        o_result.tx_byte  = frame_byte(CMD_IF_COND, 3'd0);
                                    end
                                end
                                CMD_IF_COND: begin
                                    if (i_rx_byte[2]) begin
                                        o_result.done_res = 1'b1;
                                        o_result.status   = ST_IO_ERR;
                                    end else if (i_rx_byte == R1_IDLE) begin
                                        o_result.tx_valid = 1'b1;
                                        o_result.tx_byte  = BYTE_IDLE;
                                    end else begin
                                        o_result.tx_valid = 1'b1;
                                        o_result.tx_byte  = frame_byte(CMD_APP, 3'd0);
                                    end
                                end
                                CMD_APP: begin
                                    o_result.tx_valid = 1'b1;
                                    o_result.tx_byte  = frame_byte(CMD_SEND_OP, 3'd0);
                                end
                                default: begin
                                    if (i_rx_byte == R1_READY) begin
                                        o_result.done_res = 1'b1;
                                        o_result.status   = ST_OK;
                                    end else if (retry_out) begin
                                        o_result.done_res = 1'b1;
                                        o_result.status   = ST_TIMEOUT;
                                    end else begin
                                        o_result.wait_tick = 1'b1;
                                    end
                                end
                            endcase
                        end else begin
                            o_result.tx_valid = 1'b1;
                            o_result.tx_byte  = BYTE_IDLE;
                        end
                    end
                    PH_R7: begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_byte  = (r_frame_index < R7_LAST)
                                          ? BYTE_IDLE : frame_byte(CMD_APP, 3'd0);
                    end
                    default: begin
                        o_result.tx_valid = 1'b0;
                    end
                endcase
            end
            default: begin
                o_result.tx_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_cmd         <= CMD_GO_IDLE;
            r_frame_index <= 3'd0;
            r_dummy_left  <= 4'd0;
            r_poll_count  <= 4'd0;
            r_retry_count <= 10'd0;
            r_clock_sel   <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_cmd         <= n_cmd;
            r_frame_index <= n_frame_index;
            r_dummy_left  <= n_dummy_left;
            r_poll_count  <= n_poll_count;
            r_retry_count <= n_retry_count;
            r_clock_sel   <= n_clock_sel;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sd_spi_init_sequencer.sv =====
// Top level of the SD card SPI init sequencer: input stage, config and result register.
`default_nettype none

//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | i_valid / o_stall    | i_req_type, i_rx_byte
//  result   | o_valid / i_stall    | o_tx_valid, o_tx_byte, o_wait_tick,
//           |                      | o_fast_clock, o_done_res, o_status
//  config   | i_cfg_wr_en          | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while results are not stalled; a result is offered
// via the input register, then decision logic into the result register.
// Synchronous active-low reset puts the sequencer idle, slow clock, limits at defaults.
// A stalled result holds; the input register keeps taking requests while the
// result register is free or being drained in the same cycle.

module sd_spi_init_sequencer
    import sdinit_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_req_type,
    input  wire logic [7:0]            i_rx_byte,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_tx_valid,
    output logic [7:0]                 o_tx_byte,
    output logic                       o_wait_tick,
    output logic                       o_fast_clock,
    output logic                       o_done_res,
    output logic [1:0]                 o_status,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic       r_in_valid;
    logic [1:0] r_req_type;
    logic [7:0] r_rx_byte;
    logic       r_out_valid;
    t_result    r_result;
    t_result    step_result;
    t_cfg       r_cfg;
    logic       fire;
    logic       accept;

    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;
    assign accept  = i_valid && !o_stall;

    sdinit_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_req_type (r_req_type),
        .i_rx_byte  (r_rx_byte),
        .i_cfg      (r_cfg),
        .o_result   (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dummy_bytes <= DUMMY_BYTES_RST;
            r_cfg.poll_limit  <= POLL_LIMIT_RST;
            r_cfg.retry_limit <= RETRY_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DUMMY_BYTES: r_cfg.dummy_bytes <= i_cfg_data[3:0];
                CFG_POLL_LIMIT:  r_cfg.poll_limit  <= i_cfg_data[3:0];
                CFG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg_data[9:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_rx_byte  <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= step_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tx_valid   = r_result.tx_valid;
    assign o_tx_byte    = r_result.tx_byte;
    assign o_wait_tick  = r_result.wait_tick;
    assign o_fast_clock = r_result.fast_clock;
    assign o_done_res   = r_result.done_res;
    assign o_status     = r_result.status;

endmodule

`default_nettype wire

// ===== tb/sd_spi_init_sequencer_tb.sv =====
// Self-checking testbench for the SD card SPI init sequencer: card-side stimulus and scoreboard.
`timescale 1ns / 100ps

import sdinit_pkg::*;

class init_seq_scoreboard;
    t_phase     phase;
    t_cmd       cmd;
    logic [2:0] byte_idx;
    logic [3:0] dummies_left;
    logic [3:0] polls;
    logic [9:0] retries;
    logic [7:0] last_resp;
    logic       fast_sel;
    logic [3:0] dummy_cfg;
    logic [3:0] poll_cfg;
    logic [9:0] retry_cfg;
    t_result    pending_replies[$];
    int         mismatches;

    function new();
        phase        = PH_IDLE;
        cmd          = CMD_GO_IDLE;
        byte_idx     = '0;
        dummies_left = '0;
        polls        = '0;
        retries      = '0;
        last_resp    = BYTE_IDLE;
        fast_sel     = 1'b0;
        dummy_cfg    = DUMMY_BYTES_RST;
        poll_cfg     = POLL_LIMIT_RST;
        retry_cfg    = RETRY_LIMIT_RST;
        mismatches   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DUMMY_BYTES: dummy_cfg = data[3:0];
            CFG_POLL_LIMIT:  poll_cfg  = data[3:0];
            CFG_RETRY_LIMIT: retry_cfg = data;
            default: ;
        endcase
    endfunction

    // Whole command frame as 48 bits, start byte first
    function logic [7:0] wire_byte(t_cmd c, logic [2:0] idx);
        logic [47:0] frame;
        case (c)
            CMD_GO_IDLE: frame = {CMD_START | 8'd0,  32'd0,      CRC_CMD0};
            CMD_IF_COND: frame = {CMD_START | 8'd8,  ARG_CMD8,   CRC_CMD8};
            CMD_APP:     frame = {CMD_START | 8'd55, 32'd0,      CRC_NONE};
            default:     frame = {CMD_START | 8'd41, ARG_ACMD41, CRC_NONE};
        endcase
        return frame[47 - 8 * idx -: 8];
    endfunction

    function t_result put_byte(logic [7:0] b);
        t_result r;
        r          = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = b;
        return r;
    endfunction

    function t_result open_frame(t_cmd c);
        phase    = PH_FRAME;
        cmd      = c;
        byte_idx = 3'd1;
        return put_byte(wire_byte(c, 3'd0));
    endfunction

    function t_result close_seq(logic [1:0] st);
        t_result r;
        r          = '0;
        phase      = PH_IDLE;
        r.done_res = 1'b1;
        r.status   = st;
        return r;
    endfunction

    function t_result judge_reply();
        t_result    r;
        logic [9:0] lim;
        r   = '0;
        lim = (retry_cfg == 10'd0) ? 10'd1 : retry_cfg;
        case (cmd)
            CMD_GO_IDLE: begin
                if (last_resp != R1_IDLE) r = close_seq(ST_IO_ERR);
                else r = open_frame(CMD_IF_COND);
            end
            CMD_IF_COND: begin
                if (last_resp[2]) begin
                    r = close_seq(ST_IO_ERR);
                end else if (last_resp == R1_IDLE) begin
                    // read the four R7 bytes, values ignored
                    phase    = PH_R7;
                    byte_idx = 3'd1;
                    r        = put_byte(BYTE_IDLE);
                end else begin
                    r = open_frame(CMD_APP);
                end
            end
            CMD_APP: r = open_frame(CMD_SEND_OP);
            default: begin
                if (last_resp == R1_READY) begin
                    fast_sel = 1'b1;
                    r        = close_seq(ST_OK);
                end else begin
                    retries = retries + 10'd1;
                    if (retries >= lim) begin
                        r = close_seq(ST_TIMEOUT);
                    end else begin
                        phase       = PH_WAIT;
                        r.wait_tick = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function t_result sequence_step(logic [1:0] req, logic [7:0] rx);
        t_result    r;
        logic [3:0] lim;
        r = '0;
        case (req)
            REQ_START: begin
                // restart from scratch even when busy
                fast_sel     = 1'b0;
                retries      = '0;
                polls        = '0;
                byte_idx     = '0;
                last_resp    = BYTE_IDLE;
                phase        = PH_DUMMY;
                dummies_left = (dummy_cfg == 4'd0) ? 4'd0 : dummy_cfg - 4'd1;
                r            = put_byte(BYTE_IDLE);
            end
            REQ_TICK: begin
                if (phase == PH_WAIT) r = open_frame(CMD_APP);
            end
            REQ_XFER: begin
                case (phase)
                    PH_DUMMY: begin
                        if (dummies_left != 4'd0) begin
                            dummies_left = dummies_left - 4'd1;
                            r            = put_byte(BYTE_IDLE);
                        end else begin
                            r = open_frame(CMD_GO_IDLE);
                        end
                    end
                    PH_FRAME: begin
                        if (byte_idx < FRAME_LAST) begin
                            r        = put_byte(wire_byte(cmd, byte_idx));
                            byte_idx = byte_idx + 3'd1;
                        end else begin
                            phase = PH_POLL;
                            polls = 4'd1;
                            r     = put_byte(BYTE_IDLE);
                        end
                    end
                    PH_POLL: begin
                        lim       = (poll_cfg == 4'd0) ? 4'd1 : poll_cfg;
                        last_resp = rx;
                        if (!rx[7] || polls >= lim) begin
                            r = judge_reply();
                        end else begin
                            polls = polls + 4'd1;
                            r     = put_byte(BYTE_IDLE);
                        end
                    end
                    PH_R7: begin
                        if (byte_idx < R7_LAST) begin
                            byte_idx = byte_idx + 3'd1;
                            r        = put_byte(BYTE_IDLE);
                        end else begin
                            r = open_frame(CMD_APP);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.fast_clock = fast_sel;
        return r;
    endfunction

    function void note_request(logic [1:0] req, logic [7:0] rx);
        pending_replies.push_back(sequence_step(req, rx));
    endfunction

    function void compare_field(string name, logic [7:0] exp, logic [7:0] got);
        if (got !== exp) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, exp, got);
            mismatches++;
        end
    endfunction

    function void check_result(t_result got);
        t_result exp;
        if (pending_replies.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
        end
        exp = pending_replies.pop_front();
        compare_field("tx_valid",   exp.tx_valid,   got.tx_valid);
        compare_field("tx_byte",    exp.tx_byte,    got.tx_byte);
        compare_field("wait_tick",  exp.wait_tick,  got.wait_tick);
        compare_field("fast_clock", exp.fast_clock, got.fast_clock);
        compare_field("done_res",   exp.done_res,   got.done_res);
        compare_field("status",     exp.status,     got.status);
    endfunction
endclass

module sd_spi_init_sequencer_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         ITEMS_PER_PHASE = 138;
    localparam int         CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_req_type;
    logic [7:0]            i_rx_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_tx_valid;
    logic [7:0]            o_tx_byte;
    logic                  o_wait_tick;
    logic                  o_fast_clock;
    logic                  o_done_res;
    logic [1:0]            o_status;
    logic                  i_cfg_wr_en;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    init_seq_scoreboard sb;
    init_seq_scoreboard card_view;

    int accepted;
    int useful_items;
    int burst_left;
    int cycles;
    bit long_hold_done;

    sd_spi_init_sequencer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_wait_tick  (o_wait_tick),
        .o_fast_clock (o_fast_clock),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: check every transaction taken
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.tx_valid   = o_tx_valid;
            got.tx_byte    = o_tx_byte;
            got.wait_tick  = o_wait_tick;
            got.fast_clock = o_fast_clock;
            got.done_res   = o_done_res;
            got.status     = o_status;
            sb.check_result(got);
        end
    end

    // Result side stall pattern, with one forced long hold once traffic is flowing
    initial begin
        int mode;
        int span;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!long_hold_done && accepted >= 300) begin
                long_hold_done = 1;
                span           = 80;
                mode           = 4;
            end else begin
                mode = $urandom_range(0, 9);
                span = (mode == 4) ? $urandom_range(40, 100) : $urandom_range(20, 60);
            end
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (mode)
                    0, 1, 5: i_stall = 1'b0;
                    2, 6:    i_stall = ($urandom_range(0, 2) == 0);
                    3, 7:    i_stall = (c % 3 == 2);
                    4:       i_stall = 1'b1;
                    default: i_stall = ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    task automatic send_request(logic [1:0] req, logic [7:0] rx);
        int gap;
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_req_type = req;
        i_rx_byte  = rx;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(req, rx);
        accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap        = $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic issue(logic [1:0] req, logic [7:0] rx);
        t_result r;
        r = card_view.sequence_step(req, rx);
        if (r.tx_valid || r.wait_tick || r.done_res) useful_items++;
        send_request(req, rx);
    endtask

    // Hold the sender until every expected result is back, then let the pipe settle
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        sb.write_reg(idx, data);
        card_view.write_reg(idx, data);
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] dummy, logic [CFG_DATA_W-1:0] poll,
                                  logic [CFG_DATA_W-1:0] retry);
        write_reg(CFG_DUMMY_BYTES, dummy);
        write_reg(CFG_POLL_LIMIT, poll);
        write_reg(CFG_RETRY_LIMIT, retry);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Card answer to a poll byte; busy bytes keep bit 7 set
    function automatic logic [7:0] card_reply(t_cmd c);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return 8'h80 | 8'($urandom_range(0, 127));
        case (c)
            CMD_GO_IDLE: return (roll < 90) ? R1_IDLE : 8'($urandom_range(0, 127));
            CMD_IF_COND: begin
                if (roll < 70) return R1_IDLE;
                if (roll < 80) return 8'($urandom_range(0, 127)) | 8'h04;
                return 8'($urandom_range(0, 127)) & 8'h7B;
            end
            CMD_APP: return 8'($urandom_range(0, 127));
            default: return (roll < 55) ? R1_READY : 8'($urandom_range(1, 127));
        endcase
    endfunction

    task automatic pick_request(output logic [1:0] req, output logic [7:0] rx);
        int roll;
        roll = $urandom_range(0, 99);
        rx   = 8'($urandom_range(0, 255));
        req  = REQ_XFER;
        if (roll < 3) begin
            // noise, including a restart in the middle of a sequence
            req = 2'($urandom_range(0, 3));
        end else begin
            case (card_view.phase)
                PH_IDLE: req = (roll < 90) ? REQ_START : 2'($urandom_range(1, 3));
                PH_WAIT: begin
                    if (roll < 92) req = REQ_TICK;
                    else if (roll < 96) req = REQ_XFER;
                    else req = REQ_UNUSED;
                end
                PH_POLL: rx = card_reply(card_view.cmd);
                default: req = REQ_XFER;
            endcase
        end
    endtask

    initial begin
        logic [1:0] req;
        logic [7:0] rx;
        int         d;
        int         pl;
        int         rt;

        sb             = new();
        card_view      = new();
        accepted       = 0;
        useful_items   = 0;
        burst_left     = 0;
        cycles         = 0;
        long_hold_done = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req_type     = REQ_START;
        i_rx_byte      = 8'h00;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = CFG_DUMMY_BYTES;
        i_cfg_data     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: ignored requests, restart while busy, CMD0 poll running out
        apply_settings(1, 2, 2);
        issue(REQ_UNUSED, 8'h00);
        issue(REQ_TICK, 8'hFF);
        issue(REQ_XFER, 8'hA5);
        issue(REQ_XFER, 8'h7F);
        issue(REQ_START, 8'h00);
        issue(REQ_XFER, 8'hFF);
        issue(REQ_START, 8'hFF);
        issue(REQ_XFER, 8'h00);
        repeat (5) issue(REQ_XFER, 8'hFF);
        issue(REQ_XFER, 8'h00);
        issue(REQ_XFER, 8'h80);
        issue(REQ_XFER, 8'hFF);
        issue(REQ_TICK, 8'h00);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       begin d = 1;  pl = 1;  rt = 1;    end
                1:       begin d = 15; pl = 15; rt = 1023; end
                2:       begin d = 0;  pl = 0;  rt = 0;    end
                3:       begin d = 2;  pl = 3;  rt = 2;    end
                4: begin
                    d  = $urandom_range(1, 15);
                    pl = $urandom_range(1, 15);
                    rt = $urandom_range(1, 6);
                end
                5:       begin d = 4;  pl = 15; rt = 3;    end
                6: begin
                    // upper data bits beyond the narrow registers are dropped
                    d  = $urandom_range(0, 1023);
                    pl = $urandom_range(0, 1023);
                    rt = $urandom_range(1, 8);
                    write_reg(CFG_UNUSED, 10'($urandom_range(0, 1023)));
                end
                default: begin d = 10; pl = 10; rt = 1000; end
            endcase
            apply_settings(10'(d), 10'(pl), 10'(rt));
            useful_items = 0;
            while (useful_items < ITEMS_PER_PHASE) begin
                pick_request(req, rx);
                issue(req, rx);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0t: %0d field errors, %0d results outstanding", $time,
                     sb.mismatches, sb.pending_replies.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
